### design/rft_pkg.sv
package rft_pkg;

  localparam int FRAC_BITS = 16;
  localparam int UNIT_W    = 18;
  localparam int PT_W      = 32;
  localparam int SUM_W     = 64;
  localparam int NUM_W     = PT_W + FRAC_BITS + 1;
  localparam int Q_STEPS   = FRAC_BITS + 2;
  localparam int SQ1_STEPS = SUM_W / 2;
  localparam int SQ1_TOP   = SUM_W - 2;
  localparam int SQ2_STEPS = FRAC_BITS + 2;
  localparam int SQ2_TOP   = 2 * FRAC_BITS + 2;
  localparam int SH_W      = 6;
  localparam int QSH_W     = 5;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 17;
  localparam int MINL_W    = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_LENGTH   = 2'd0,
    CFG_UP_THRESHOLD = 2'd1
  } cfg_idx_t;

  // Per-item data that rides along each cell of the chain.
  typedef struct packed {
    logic                     valid;
    logic [2:0][PT_W-1:0]     s;
    logic [2:0][PT_W-1:0]     d;
    logic [2:0][UNIT_W-1:0]   z;
    logic [2:0][UNIT_W-1:0]   c;
    logic [2:0]               neg;
  } side_t;

endpackage

### design/rft_if.sv
interface rft_seg_if;
  logic                               valid;
  logic                               ready;
  logic signed [rft_pkg::PT_W-1:0]    start_x;
  logic signed [rft_pkg::PT_W-1:0]    start_y;
  logic signed [rft_pkg::PT_W-1:0]    start_z;
  logic signed [rft_pkg::PT_W-1:0]    end_x;
  logic signed [rft_pkg::PT_W-1:0]    end_y;
  logic signed [rft_pkg::PT_W-1:0]    end_z;
  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  input ready);
  modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                output ready);
endinterface

interface rft_res_if;
  logic                               valid;
  logic                               ready;
  logic signed [rft_pkg::UNIT_W-1:0]  side_x;
  logic signed [rft_pkg::UNIT_W-1:0]  side_y;
  logic signed [rft_pkg::UNIT_W-1:0]  side_z;
  logic signed [rft_pkg::UNIT_W-1:0]  upv_x;
  logic signed [rft_pkg::UNIT_W-1:0]  upv_y;
  logic signed [rft_pkg::UNIT_W-1:0]  upv_z;
  logic signed [rft_pkg::PT_W-1:0]    span_x;
  logic signed [rft_pkg::PT_W-1:0]    span_y;
  logic signed [rft_pkg::PT_W-1:0]    span_z;
  logic signed [rft_pkg::PT_W-1:0]    origin_x;
  logic signed [rft_pkg::PT_W-1:0]    origin_y;
  logic signed [rft_pkg::PT_W-1:0]    origin_z;
  modport source (output valid, side_x, side_y, side_z, upv_x, upv_y, upv_z,
                  span_x, span_y, span_z, origin_x, origin_y, origin_z,
                  input ready);
  modport sink (input valid, side_x, side_y, side_z, upv_x, upv_y, upv_z,
                span_x, span_y, span_z, origin_x, origin_y, origin_z,
                output ready);
endinterface

interface rft_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [rft_pkg::CFG_IDX_W-1:0]      index;
  logic [rft_pkg::CFG_DAT_W-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### design/rft_sqrt_cell.sv
module rft_sqrt_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic [rft_pkg::SH_W-1:0]     shift,
  input  rft_pkg::side_t               side_in,
  input  logic [rft_pkg::SUM_W-1:0]    rem_in,
  input  logic [rft_pkg::SUM_W-1:0]    root_in,
  output rft_pkg::side_t               side_out,
  output logic [rft_pkg::SUM_W-1:0]    rem_out,
  output logic [rft_pkg::SUM_W-1:0]    root_out
);

  logic [rft_pkg::SUM_W-1:0] bitv;
  logic [rft_pkg::SUM_W:0]   trial;
  logic                      take;
  logic [rft_pkg::SUM_W-1:0] rem_next;
  logic [rft_pkg::SUM_W-1:0] root_next;

  // One root bit: subtract the trial term when it fits
  always_comb begin
    bitv      = rft_pkg::SUM_W'(1) << shift;
    trial     = {1'b0, root_in} + {1'b0, bitv};
    take      = {1'b0, rem_in} >= trial;
    rem_next  = take ? rem_in - trial[rft_pkg::SUM_W-1:0] : rem_in;
    root_next = take ? (root_in >> 1) + bitv : root_in >> 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.valid <= 1'b0;
    end else if (en) begin
      side_out <= side_in;
      rem_out  <= rem_next;
      root_out <= root_next;
    end
  end

endmodule

### design/rft_div_cell.sv
module rft_div_cell (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic [rft_pkg::QSH_W-1:0]             shift,
  input  rft_pkg::side_t                        side_in,
  input  logic [rft_pkg::PT_W-1:0]              den_in,
  input  logic [2:0][rft_pkg::NUM_W-1:0]        rem_in,
  input  logic [2:0][rft_pkg::UNIT_W-1:0]       q_in,
  output rft_pkg::side_t                        side_out,
  output logic [rft_pkg::PT_W-1:0]              den_out,
  output logic [2:0][rft_pkg::NUM_W-1:0]        rem_out,
  output logic [2:0][rft_pkg::UNIT_W-1:0]       q_out
);

  logic [rft_pkg::NUM_W:0]              dsh;
  logic [2:0][rft_pkg::NUM_W-1:0]       rem_next;
  logic [2:0][rft_pkg::UNIT_W-1:0]      q_next;

  // One quotient bit for each of the three lanes
  always_comb begin
    dsh = (rft_pkg::NUM_W+1)'(den_in) << shift;
    for (int i = 0; i < 3; i++) begin
      if ({1'b0, rem_in[i]} >= dsh) begin
        rem_next[i] = rem_in[i] - dsh[rft_pkg::NUM_W-1:0];
        q_next[i]   = q_in[i] | (rft_pkg::UNIT_W'(1) << shift);
      end else begin
        rem_next[i] = rem_in[i];
        q_next[i]   = q_in[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.valid <= 1'b0;
    end else if (en) begin
      side_out <= side_in;
      den_out  <= den_in;
      rem_out  <= rem_next;
      q_out    <= q_next;
    end
  end

endmodule

### design/ray_frame_transform_top.sv
// Order: stages A-C, length root, D, direction divide, E-G, side root, H, side divide, I-K.
// Throughput: one segment per cycle; every square-root bit and quotient bit is its
// own cell, so a new beat enters each cycle while earlier ones move down the chain.
// The whole chain advances when the output register is empty or taken.
// Reset (rst, synchronous): clears all valid flags; min_length = 7, up_threshold = 65470.
module ray_frame_transform_top (
  input  logic        clk,
  input  logic        rst,
  rft_seg_if.sink     seg,
  rft_res_if.source   res,
  rft_cfg_if.sink     cfg
);

  localparam int ONE = 1 << rft_pkg::FRAC_BITS;

  logic                        en;
  logic [rft_pkg::MINL_W-1:0]  min_length;
  logic [rft_pkg::UNIT_W-2:0]  up_threshold;

  assign cfg.ready = 1'b1;
  assign en        = !res.valid || res.ready;
  assign seg.ready = en;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_length   <= rft_pkg::MINL_W'(7);
      up_threshold <= (rft_pkg::UNIT_W-1)'(65470);
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        rft_pkg::CFG_MIN_LENGTH:   min_length   <= cfg.data[rft_pkg::MINL_W-1:0];
        rft_pkg::CFG_UP_THRESHOLD: up_threshold <= cfg.data;
        default: ;
      endcase
    end
  end

  // Stage A: saturated direction
  rft_pkg::side_t a_side, a_side_next;
  logic signed [rft_pkg::PT_W:0] diff [3];
  logic signed [rft_pkg::PT_W-1:0] sp [3];
  logic signed [rft_pkg::PT_W-1:0] ep [3];

  always_comb begin
    sp[0] = seg.start_x; sp[1] = seg.start_y; sp[2] = seg.start_z;
    ep[0] = seg.end_x;   ep[1] = seg.end_y;   ep[2] = seg.end_z;
    a_side_next       = '0;
    a_side_next.valid = seg.valid;
    for (int i = 0; i < 3; i++) begin
      diff[i] = (rft_pkg::PT_W+1)'(ep[i]) - (rft_pkg::PT_W+1)'(sp[i]);
      a_side_next.s[i] = sp[i];
      if (diff[i][rft_pkg::PT_W] != diff[i][rft_pkg::PT_W-1])
        a_side_next.d[i] = diff[i][rft_pkg::PT_W] ? {1'b1, {(rft_pkg::PT_W-1){1'b0}}}
                                                  : {1'b0, {(rft_pkg::PT_W-1){1'b1}}};
      else
        a_side_next.d[i] = diff[i][rft_pkg::PT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) a_side.valid <= 1'b0;
    else if (en) a_side <= a_side_next;
  end

  // Stage B: squares of the direction
  rft_pkg::side_t b_side;
  logic [2*rft_pkg::PT_W-2:0] b_sq [3];
  logic [rft_pkg::PT_W-1:0]   a_mag [3];

  always_comb begin
    for (int i = 0; i < 3; i++)
      a_mag[i] = a_side.d[i][rft_pkg::PT_W-1] ? ~a_side.d[i] + 1'b1 : a_side.d[i];
  end

  always_ff @(posedge clk) begin
    if (rst) b_side.valid <= 1'b0;
    else if (en) begin
      b_side <= a_side;
      for (int i = 0; i < 3; i++)
        b_sq[i] <= (2*rft_pkg::PT_W-1)'(a_mag[i] * a_mag[i]);
    end
  end

  // Stage C: sum of squares, head of the first root chain
  rft_pkg::side_t          c_side;
  logic [rft_pkg::SUM_W-1:0] c_sum;

  always_ff @(posedge clk) begin
    if (rst) c_side.valid <= 1'b0;
    else if (en) begin
      c_side <= b_side;
      c_sum  <= rft_pkg::SUM_W'(b_sq[0]) + rft_pkg::SUM_W'(b_sq[1])
              + rft_pkg::SUM_W'(b_sq[2]);
    end
  end

  // Length chain
  rft_pkg::side_t            s1_side [rft_pkg::SQ1_STEPS+1];
  logic [rft_pkg::SUM_W-1:0] s1_rem  [rft_pkg::SQ1_STEPS+1];
  logic [rft_pkg::SUM_W-1:0] s1_root [rft_pkg::SQ1_STEPS+1];

  assign s1_side[0] = c_side;
  assign s1_rem[0]  = c_sum;
  assign s1_root[0] = '0;

  for (genvar k = 0; k < rft_pkg::SQ1_STEPS; k++) begin : g_sq1
    rft_sqrt_cell u_cell (
      .clk, .rst, .en,
      .shift    (rft_pkg::SH_W'(rft_pkg::SQ1_TOP - 2*k)),
      .side_in  (s1_side[k]),
      .rem_in   (s1_rem[k]),
      .root_in  (s1_root[k]),
      .side_out (s1_side[k+1]),
      .rem_out  (s1_rem[k+1]),
      .root_out (s1_root[k+1])
    );
  end

  // Stage D: drop short segments, set up the direction division
  rft_pkg::side_t                      d_side, d_side_next;
  logic [rft_pkg::PT_W-1:0]            d_den;
  logic [2:0][rft_pkg::NUM_W-1:0]      d_num, d_num_next;
  logic [rft_pkg::PT_W-1:0]            len;
  logic [rft_pkg::PT_W-1:0]            dmag [3];

  always_comb begin
    len         = s1_root[rft_pkg::SQ1_STEPS][rft_pkg::PT_W-1:0];
    d_side_next = s1_side[rft_pkg::SQ1_STEPS];
    d_side_next.valid = d_side_next.valid && (len != '0)
                        && (len >= rft_pkg::PT_W'(min_length));
    for (int i = 0; i < 3; i++) begin
      d_side_next.neg[i] = d_side_next.d[i][rft_pkg::PT_W-1];
      dmag[i] = d_side_next.neg[i] ? ~d_side_next.d[i] + 1'b1 : d_side_next.d[i];
      d_num_next[i] = {1'b0, dmag[i], {rft_pkg::FRAC_BITS{1'b0}}}
                    + rft_pkg::NUM_W'(len >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) d_side.valid <= 1'b0;
    else if (en) begin
      d_side <= d_side_next;
      d_den  <= len;
      d_num  <= d_num_next;
    end
  end

  // Unit-direction division chain
  rft_pkg::side_t                       q1_side [rft_pkg::Q_STEPS+1];
  logic [rft_pkg::PT_W-1:0]             q1_den  [rft_pkg::Q_STEPS+1];
  logic [2:0][rft_pkg::NUM_W-1:0]       q1_rem  [rft_pkg::Q_STEPS+1];
  logic [2:0][rft_pkg::UNIT_W-1:0]      q1_q    [rft_pkg::Q_STEPS+1];

  assign q1_side[0] = d_side;
  assign q1_den[0]  = d_den;
  assign q1_rem[0]  = d_num;
  assign q1_q[0]    = '0;

  for (genvar k = 0; k < rft_pkg::Q_STEPS; k++) begin : g_q1
    rft_div_cell u_cell (
      .clk, .rst, .en,
      .shift    (rft_pkg::QSH_W'(rft_pkg::Q_STEPS - 1 - k)),
      .side_in  (q1_side[k]),
      .den_in   (q1_den[k]),
      .rem_in   (q1_rem[k]),
      .q_in     (q1_q[k]),
      .side_out (q1_side[k+1]),
      .den_out  (q1_den[k+1]),
      .rem_out  (q1_rem[k+1]),
      .q_out    (q1_q[k+1])
    );
  end

  // Stage E: signed unit direction and helper-axis cross product
  rft_pkg::side_t                 e_side, e_side_next;
  logic [rft_pkg::UNIT_W-1:0]     qz [3];
  logic signed [rft_pkg::UNIT_W-1:0] zy_s;
  logic [rft_pkg::UNIT_W-2:0]     ay;

  always_comb begin
    e_side_next = q1_side[rft_pkg::Q_STEPS];
    for (int i = 0; i < 3; i++) begin
      qz[i] = q1_q[rft_pkg::Q_STEPS][i];
      e_side_next.z[i] = e_side_next.neg[i] ? ~qz[i] + 1'b1 : qz[i];
    end
    zy_s = e_side_next.z[1];
    ay   = zy_s[rft_pkg::UNIT_W-1] ? (rft_pkg::UNIT_W-1)'(-zy_s)
                                   : (rft_pkg::UNIT_W-1)'(zy_s);
    if (ay < up_threshold) begin
      e_side_next.c[0] = e_side_next.z[2];
      e_side_next.c[1] = '0;
      e_side_next.c[2] = ~e_side_next.z[0] + 1'b1;
    end else begin
      e_side_next.c[0] = '0;
      e_side_next.c[1] = ~e_side_next.z[2] + 1'b1;
      e_side_next.c[2] = e_side_next.z[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) e_side.valid <= 1'b0;
    else if (en) e_side <= e_side_next;
  end

  // Stage F: squares of the cross product
  rft_pkg::side_t              f_side;
  logic [2*rft_pkg::UNIT_W-1:0] f_sq [3];
  logic [rft_pkg::UNIT_W-1:0]  cmag [3];

  always_comb begin
    for (int i = 0; i < 3; i++)
      cmag[i] = e_side.c[i][rft_pkg::UNIT_W-1] ? ~e_side.c[i] + 1'b1 : e_side.c[i];
  end

  always_ff @(posedge clk) begin
    if (rst) f_side.valid <= 1'b0;
    else if (en) begin
      f_side <= e_side;
      for (int i = 0; i < 3; i++) f_sq[i] <= cmag[i] * cmag[i];
    end
  end

  // Stage G: sum, head of the second root chain
  rft_pkg::side_t            g_side;
  logic [rft_pkg::SUM_W-1:0] g_sum;

  always_ff @(posedge clk) begin
    if (rst) g_side.valid <= 1'b0;
    else if (en) begin
      g_side <= f_side;
      g_sum  <= rft_pkg::SUM_W'(f_sq[0]) + rft_pkg::SUM_W'(f_sq[1])
              + rft_pkg::SUM_W'(f_sq[2]);
    end
  end

  rft_pkg::side_t            s2_side [rft_pkg::SQ2_STEPS+1];
  logic [rft_pkg::SUM_W-1:0] s2_rem  [rft_pkg::SQ2_STEPS+1];
  logic [rft_pkg::SUM_W-1:0] s2_root [rft_pkg::SQ2_STEPS+1];

  assign s2_side[0] = g_side;
  assign s2_rem[0]  = g_sum;
  assign s2_root[0] = '0;

  for (genvar k = 0; k < rft_pkg::SQ2_STEPS; k++) begin : g_sq2
    rft_sqrt_cell u_cell (
      .clk, .rst, .en,
      .shift    (rft_pkg::SH_W'(rft_pkg::SQ2_TOP - 2*k)),
      .side_in  (s2_side[k]),
      .rem_in   (s2_rem[k]),
      .root_in  (s2_root[k]),
      .side_out (s2_side[k+1]),
      .rem_out  (s2_rem[k+1]),
      .root_out (s2_root[k+1])
    );
  end

  // Stage H: set up the side-vector division
  rft_pkg::side_t                  h_side, h_side_next;
  logic [rft_pkg::PT_W-1:0]        h_den, cn;
  logic [2:0][rft_pkg::NUM_W-1:0]  h_num, h_num_next;
  logic [rft_pkg::UNIT_W-1:0]      hmag [3];

  always_comb begin
    cn          = s2_root[rft_pkg::SQ2_STEPS][rft_pkg::PT_W-1:0];
    h_side_next = s2_side[rft_pkg::SQ2_STEPS];
    for (int i = 0; i < 3; i++) begin
      h_side_next.neg[i] = h_side_next.c[i][rft_pkg::UNIT_W-1];
      hmag[i] = h_side_next.neg[i] ? ~h_side_next.c[i] + 1'b1 : h_side_next.c[i];
      h_num_next[i] = rft_pkg::NUM_W'({hmag[i], {rft_pkg::FRAC_BITS{1'b0}}})
                    + rft_pkg::NUM_W'(cn >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) h_side.valid <= 1'b0;
    else if (en) begin
      h_side <= h_side_next;
      h_den  <= cn;
      h_num  <= h_num_next;
    end
  end

  rft_pkg::side_t                       q2_side [rft_pkg::Q_STEPS+1];
  logic [rft_pkg::PT_W-1:0]             q2_den  [rft_pkg::Q_STEPS+1];
  logic [2:0][rft_pkg::NUM_W-1:0]       q2_rem  [rft_pkg::Q_STEPS+1];
  logic [2:0][rft_pkg::UNIT_W-1:0]      q2_q    [rft_pkg::Q_STEPS+1];

  assign q2_side[0] = h_side;
  assign q2_den[0]  = h_den;
  assign q2_rem[0]  = h_num;
  assign q2_q[0]    = '0;

  for (genvar k = 0; k < rft_pkg::Q_STEPS; k++) begin : g_q2
    rft_div_cell u_cell (
      .clk, .rst, .en,
      .shift    (rft_pkg::QSH_W'(rft_pkg::Q_STEPS - 1 - k)),
      .side_in  (q2_side[k]),
      .den_in   (q2_den[k]),
      .rem_in   (q2_rem[k]),
      .q_in     (q2_q[k]),
      .side_out (q2_side[k+1]),
      .den_out  (q2_den[k+1]),
      .rem_out  (q2_rem[k+1]),
      .q_out    (q2_q[k+1])
    );
  end

  // Stage I: signed side vector, zero when the cross product vanished
  rft_pkg::side_t                    i_side;
  logic signed [rft_pkg::UNIT_W-1:0] i_sd [3];
  logic [rft_pkg::UNIT_W-1:0]        qs [3];
  logic signed [rft_pkg::UNIT_W-1:0] sd_next [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qs[i] = q2_q[rft_pkg::Q_STEPS][i];
      if (q2_den[rft_pkg::Q_STEPS] == '0)
        sd_next[i] = '0;
      else
        sd_next[i] = q2_side[rft_pkg::Q_STEPS].neg[i] ? ~qs[i] + 1'b1 : qs[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) i_side.valid <= 1'b0;
    else if (en) begin
      i_side <= q2_side[rft_pkg::Q_STEPS];
      for (int i = 0; i < 3; i++) i_sd[i] <= sd_next[i];
    end
  end

  // Stage J: cross-product terms of z and side
  rft_pkg::side_t                      j_side;
  logic signed [rft_pkg::UNIT_W-1:0]   j_sd [3];
  logic signed [2*rft_pkg::UNIT_W-1:0] j_pa [3];
  logic signed [2*rft_pkg::UNIT_W-1:0] j_pb [3];
  logic signed [rft_pkg::UNIT_W-1:0]   zs [3];

  always_comb begin
    for (int i = 0; i < 3; i++) zs[i] = i_side.z[i];
  end

  always_ff @(posedge clk) begin
    if (rst) j_side.valid <= 1'b0;
    else if (en) begin
      j_side <= i_side;
      j_sd   <= i_sd;
      j_pa[0] <= zs[1] * i_sd[2];
      j_pb[0] <= zs[2] * i_sd[1];
      j_pa[1] <= zs[2] * i_sd[0];
      j_pb[1] <= zs[0] * i_sd[2];
      j_pa[2] <= zs[0] * i_sd[1];
      j_pb[2] <= zs[1] * i_sd[0];
    end
  end

  // Stage K: round, saturate and hold the result beat
  logic signed [2*rft_pkg::UNIT_W:0]   cd   [3];
  logic [2*rft_pkg::UNIT_W:0]          cdm  [3];
  logic [2*rft_pkg::UNIT_W:0]          rq   [3];
  logic [rft_pkg::UNIT_W-1:0]          um   [3];
  logic signed [rft_pkg::UNIT_W-1:0]   u_next [3];
  logic                                out_v;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cd[i]  = (2*rft_pkg::UNIT_W+1)'(j_pa[i]) - (2*rft_pkg::UNIT_W+1)'(j_pb[i]);
      cdm[i] = cd[i][2*rft_pkg::UNIT_W] ? ~cd[i] + 1'b1 : cd[i];
      rq[i]  = (cdm[i] + (2*rft_pkg::UNIT_W+1)'(ONE >> 1)) >> rft_pkg::FRAC_BITS;
      um[i]  = (rq[i] > (2*rft_pkg::UNIT_W+1)'(ONE)) ? rft_pkg::UNIT_W'(ONE)
                                                     : rq[i][rft_pkg::UNIT_W-1:0];
      u_next[i] = cd[i][2*rft_pkg::UNIT_W] ? ~um[i] + 1'b1 : um[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_v <= 1'b0;
    else if (en) begin
      out_v        <= j_side.valid;
      res.side_x   <= j_sd[0];
      res.side_y   <= j_sd[1];
      res.side_z   <= j_sd[2];
      res.upv_x    <= u_next[0];
      res.upv_y    <= u_next[1];
      res.upv_z    <= u_next[2];
      res.span_x   <= j_side.d[0];
      res.span_y   <= j_side.d[1];
      res.span_z   <= j_side.d[2];
      res.origin_x <= j_side.s[0];
      res.origin_y <= j_side.s[1];
      res.origin_z <= j_side.s[2];
    end
  end

  assign res.valid = out_v;

endmodule
